>>> design/lcg_pkg.sv
package lcg_pkg;
    localparam int CELL_W = 5;
    localparam int CNT_W = 4;
    localparam int CHG_W = 13;
    localparam int CFG_W = 7;
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_GEN = 2'd3;
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic [CHG_W-1:0] CHANGED_MAX = 13'h1FFF;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] x;
        logic [5:0] y;
    } t_req;

    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] neighbours;
        logic [CHG_W-1:0] changed_cells;
    } t_rsp;

    typedef struct packed {
        logic       index;
        logic [6:0] data;
    } t_cfg;
endpackage

>>> design/lcg_if.sv
interface lcg_req_if;
    import lcg_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface lcg_rsp_if;
    import lcg_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface lcg_cfg_if;
    import lcg_pkg::*;
    logic valid;
    logic ready;
    logic [7:0] index;
    logic [6:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> design/lcg_ram.sv
module lcg_ram
    import lcg_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);
    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> design/life_cellmap_generation.sv
// channel  | dir | handshake     | payload
// i_req    | in  | valid/ready   | op, x, y
// o_rsp    | out | valid/ready   | alive, neighbours, changed_cells
// i_cfg    | in  | valid/ready   | index, data (width/height in use)
// Set/clear/read: up to 42 modulo passes and a cell read, and for a set or clear that
// changes the cell, a cell write plus eight neighbour updates.
// A generation first copies each cell in use into the snapshot memory, then scans each
// cell and rewrites every cell that flips together with its ring.
// After reset a clearing pass zeroes all MAP_WIDTH*MAP_HEIGHT cells; no item is taken then.
// A result waits in the output register; the next item is taken once it is gone.
module life_cellmap_generation
    import lcg_pkg::*;
#(
    parameter int MAP_WIDTH = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcg_req_if.sink     i_req,
    lcg_rsp_if.source   o_rsp,
    lcg_cfg_if.sink     i_cfg
);
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = $clog2(MAP_WIDTH);
    localparam int YW = $clog2(MAP_HEIGHT);
    localparam logic [CFG_W-1:0] MIN_DIM = 7'd3;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MOD = 4'd2, S_RD = 4'd3,
        S_WAIT = 4'd4, S_CELL = 4'd5, S_RING = 4'd6, S_RINGW = 4'd7, S_OUT = 4'd8,
        S_CPY = 4'd9, S_SCAN = 4'd10, S_SCANW = 4'd11, S_RESP = 4'd12, S_CPYW = 4'd13,
        S_EVAL = 4'd15;

    logic [3:0] r_state;
    logic [CFG_W-1:0] r_wcfg, r_hcfg;
    logic [XW:0] w_act;
    logic [YW:0] h_act;
    logic [AW:0] r_clr;
    logic [1:0] r_op;
    logic [XW-1:0] r_x, r_sx;
    logic [YW-1:0] r_y, r_sy;
    logic r_gen, r_up;
    logic [3:0] r_ring;
    logic [CHG_W-1:0] r_chg;
    logic [XW-1:0] r_cx;
    logic [YW-1:0] r_cy;
    logic [CELL_W-1:0] r_cpy;
    t_rsp r_rsp;
    logic r_ovalid;

    logic c_we, s_we;
    logic [AW-1:0] c_wa, c_ra, s_a;
    logic [CELL_W-1:0] c_wd, c_rd, s_rd;

    lcg_ram #(.DEPTH(DEPTH), .AW(AW)) u_cells (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    lcg_ram #(.DEPTH(DEPTH), .AW(AW)) u_snap (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_a), .i_wdata(r_cpy),
        .i_raddr(s_a), .o_rdata(s_rd));

    always_comb begin
        w_act = (r_wcfg < MIN_DIM) ? (XW+1)'(3)
              : (32'(r_wcfg) > 32'(MAP_WIDTH)) ? (XW+1)'(MAP_WIDTH) : (XW+1)'(r_wcfg);
        h_act = (r_hcfg < MIN_DIM) ? (YW+1)'(3)
              : (32'(r_hcfg) > 32'(MAP_HEIGHT)) ? (YW+1)'(MAP_HEIGHT) : (YW+1)'(r_hcfg);
    end

    function automatic logic [AW-1:0] f_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        f_addr = AW'(y) * AW'(MAP_WIDTH) + AW'(x);
    endfunction

    // neighbour coordinates of the current cell for ring step
    logic [XW-1:0] xl, xr, nx;
    logic [YW-1:0] ya, yb, ny;
    always_comb begin
        xl = (r_x == '0) ? XW'(w_act - 1'b1) : r_x - 1'b1;
        xr = ((XW+1)'(r_x) + 1'b1 >= w_act) ? '0 : r_x + 1'b1;
        ya = (r_y == '0) ? YW'(h_act - 1'b1) : r_y - 1'b1;
        yb = ((YW+1)'(r_y) + 1'b1 >= h_act) ? '0 : r_y + 1'b1;
        case (r_ring)
            4'd0: begin nx = xl; ny = ya; end
            4'd1: begin nx = r_x; ny = ya; end
            4'd2: begin nx = xr; ny = ya; end
            4'd3: begin nx = xl; ny = r_y; end
            4'd4: begin nx = xr; ny = r_y; end
            4'd5: begin nx = xl; ny = yb; end
            4'd6: begin nx = r_x; ny = yb; end
            default: begin nx = xr; ny = yb; end
        endcase
    end

    // x mod width and y mod height by repeated subtract, one pass per cycle, up to 21 passes per coordinate
    logic [5:0] r_mx, r_my;

    logic [CNT_W-1:0] cnt_adj;
    always_comb begin
        cnt_adj = c_rd[4:1];
        if (r_up) begin
            if (cnt_adj < 4'd8) cnt_adj = cnt_adj + 1'b1;
        end else if (cnt_adj != '0) begin
            cnt_adj = cnt_adj - 1'b1;
        end
    end

    logic s_last;
    assign s_last = ((XW+1)'(r_cx) == w_act - 1'b1) && ((YW+1)'(r_cy) == h_act - 1'b1);

    always_comb begin
        c_we = 1'b0; c_wa = f_addr(r_x, r_y); c_wd = '0; c_ra = f_addr(r_x, r_y);
        s_we = 1'b0; s_a = f_addr(r_cx, r_cy);
        case (r_state)
            S_CLR: begin c_we = 1'b1; c_wa = r_clr[AW-1:0]; end
            S_CELL: begin
                c_we = 1'b1;
                c_wd = {c_rd[4:1], r_up};
            end
            // hold the neighbour address so its data is still there at the write
            S_RING, S_OUT: c_ra = f_addr(nx, ny);
            S_RINGW: begin
                c_we = 1'b1; c_wa = f_addr(nx, ny); c_wd = {cnt_adj, c_rd[0]};
            end
            S_CPY: c_ra = f_addr(r_cx, r_cy);
            S_CPYW: s_we = 1'b1;
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_wcfg <= 7'd64; r_hcfg <= 7'd64;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == 8'(CFG_WIDTH)) r_wcfg <= i_cfg.data;
                else if (i_cfg.index == 8'(CFG_HEIGHT)) r_hcfg <= i_cfg.data;
            end
            if (r_ovalid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_req.valid && !r_ovalid) begin
                    r_op <= i_req.payload.op; r_mx <= i_req.payload.x;
                    r_my <= i_req.payload.y; r_gen <= 1'b0;
                    r_cx <= '0; r_cy <= '0; r_chg <= '0;
                    r_state <= (i_req.payload.op == OP_GEN) ? S_CPY : S_MOD;
                end
                S_MOD: begin
                    // reduce modulo size, one subtract per cycle
                    if (7'(r_mx) >= 7'(w_act)) r_mx <= r_mx - 6'(w_act);
                    else if (7'(r_my) >= 7'(h_act)) r_my <= r_my - 6'(h_act);
                    else begin
                        r_x <= XW'(r_mx); r_y <= YW'(r_my);
                        r_up <= (r_op == OP_SET); r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: begin
                    if ((r_op == OP_SET && !c_rd[0]) || (r_op == OP_CLEAR && c_rd[0]))
                        r_state <= S_CELL;
                    else if (r_gen) r_state <= S_SCAN;
                    else begin
                        r_rsp <= '{alive: c_rd[0], neighbours: c_rd[4:1], changed_cells: '0};
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_CELL: begin r_ring <= '0; r_state <= S_RING; end
                S_RING: r_state <= S_OUT;
                S_OUT: r_state <= S_RINGW;
                S_RINGW: begin
                    r_ring <= r_ring + 1'b1;
                    if (r_ring == 4'd7) r_state <= r_gen ? S_SCAN : S_RD;
                    else r_state <= S_RING;
                end
                S_CPY: r_state <= S_RESP;
                S_RESP: begin r_cpy <= c_rd; r_state <= S_CPYW; end
                S_CPYW: begin
                    if (s_last) begin
                        r_cx <= '0; r_cy <= '0; r_gen <= 1'b1; r_state <= S_SCANW;
                    end else begin
                        if ((XW+1)'(r_cx) == w_act - 1'b1) begin
                            r_cx <= '0; r_cy <= r_cy + 1'b1;
                        end else r_cx <= r_cx + 1'b1;
                        r_state <= S_CPY;
                    end
                end
                S_SCANW: begin
                    // snapshot read of (r_cx,r_cy) issued this cycle
                    r_sx <= r_cx; r_sy <= r_cy; r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_x <= r_sx; r_y <= r_sy;
                    // read the live cell first, its count has moved since the copy
                    if (s_rd[0] && s_rd[4:1] != 4'd2 && s_rd[4:1] != 4'd3) begin
                        r_op <= OP_CLEAR; r_up <= 1'b0; r_state <= S_RD;
                        if (r_chg != CHANGED_MAX) r_chg <= r_chg + 1'b1;
                    end else if (!s_rd[0] && s_rd[4:1] == 4'd3) begin
                        r_op <= OP_SET; r_up <= 1'b1; r_state <= S_RD;
                        if (r_chg != CHANGED_MAX) r_chg <= r_chg + 1'b1;
                    end else r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if ((XW+1)'(r_sx) == w_act - 1'b1 && (YW+1)'(r_sy) == h_act - 1'b1) begin
                        r_rsp <= '{alive: 1'b0, neighbours: '0, changed_cells: r_chg};
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        if ((XW+1)'(r_sx) == w_act - 1'b1) begin
                            r_cx <= '0; r_cy <= r_sy + 1'b1;
                        end else begin
                            r_cx <= r_sx + 1'b1; r_cy <= r_sy;
                        end
                        r_state <= S_SCANW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
